[design/assert_macros.svh]
// Assertion macros used by the generation step module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/ww_pkg.sv]
// Types, constants and helpers for the wireworld generation step.
package ww_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COORD_W  = 10;   // out_row / out_col width
    localparam int DIM_W    = 11;   // grid_width / grid_height width
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W   = $clog2(MAX_WIDTH);

    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        CELL_EMPTY = 2'd0,
        CELL_HEAD  = 2'd1,
        CELL_TAIL  = 2'd2,
        CELL_COND  = 2'd3
    } ww_cell_t;

    // Column of the stencil: [1:0] top, [3:2] middle, [5:4] bottom.
    typedef logic [5:0] ww_triple_t;

    typedef struct packed {
        logic [1:0] upper;
        logic [1:0] middle;
    } ww_pair_t;

    typedef struct packed {
        logic [1:0]         next_state;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               end_of_generation;
    } ww_result_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

[design/ww_if.sv]
// Stream interfaces for cell words in and result words out.
interface ww_cell_if
    import ww_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] cell_state;
    logic       flush;

    modport source (output valid, cell_state, flush, input ready);
    modport sink   (input valid, cell_state, flush, output ready);
endinterface

interface ww_result_if
    import ww_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         next_state;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               end_of_generation;

    modport source (output valid, next_state, out_row, out_col, end_of_generation,
                    input ready);
    modport sink   (input valid, next_state, out_row, out_col, end_of_generation,
                    output ready);
endinterface

[design/ww_line_mem.sv]
// Two line stores packed in one memory, one write and one registered read.
module ww_line_mem
    import ww_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  ww_pair_t          wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output ww_pair_t          rd_data
);

    ww_pair_t mem [MAX_WIDTH];
    ww_pair_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        // width of one: the column just written is read back at once
        if (wr_en && (wr_addr == rd_addr))
            rd_reg <= wr_data;
        else
            rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

[design/ww_cell_rule.sv]
// Wireworld update rule over a 3x3 neighborhood.
module ww_cell_rule
    import ww_pkg::*;
(
    input  ww_triple_t left,
    input  ww_triple_t cen,
    input  ww_triple_t right,
    output logic [1:0] next_state
);

    logic [7:0] hit;
    logic [3:0] heads;

    always_comb
    begin
        hit[0] = (left[1:0]  == CELL_HEAD);
        hit[1] = (left[3:2]  == CELL_HEAD);
        hit[2] = (left[5:4]  == CELL_HEAD);
        hit[3] = (cen[1:0]   == CELL_HEAD);
        hit[4] = (cen[5:4]   == CELL_HEAD);
        hit[5] = (right[1:0] == CELL_HEAD);
        hit[6] = (right[3:2] == CELL_HEAD);
        hit[7] = (right[5:4] == CELL_HEAD);
        heads = '0;
        for (int i = 0; i < 8; i++)
            heads = heads + {3'b000, hit[i]};

        case (cen[3:2])
            CELL_HEAD: next_state = CELL_TAIL;
            CELL_TAIL: next_state = CELL_COND;
            CELL_COND:
            begin
                if (heads inside {4'd1, 4'd2})
                    next_state = CELL_HEAD;
                else
                    next_state = CELL_COND;
            end
            default:   next_state = CELL_EMPTY;
        endcase
    end

endmodule

[design/ww_out_queue.sv]
// Two-entry output queue that drives the result stream.
module ww_out_queue
    import ww_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ww_result_t  push_data,
    output logic        can_accept,
    ww_result_if.source out_ch
);

    logic [1:0] count_reg, count_next;
    ww_result_t e0_reg, e1_reg;
    logic       pop;

    assign pop        = out_ch.valid && out_ch.ready;
    assign can_accept = (count_reg != 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && (count_reg == 2'd2))
            e0_reg <= e1_reg;
        if (push)
        begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop))
                e0_reg <= push_data;
            else
                e1_reg <= push_data;
        end
    end

    assign out_ch.valid             = (count_reg != 2'd0);
    assign out_ch.next_state        = e0_reg.next_state;
    assign out_ch.out_row           = e0_reg.out_row;
    assign out_ch.out_col           = e0_reg.out_col;
    assign out_ch.end_of_generation = e0_reg.end_of_generation;

endmodule

[design/wireworld_generation_step.sv]
// One Wireworld generation over a raster-order cell stream, one cell word per
// clock. A word is taken every cycle while the two-entry output queue has room,
// so the block sustains one cell per cycle; the result for a cell leaves one row
// plus one cell after it went in, and after the last cell of a frame the host
// sends flush words (one row plus one cell of them) to drain it. The two line
// stores share one 1024 x 4-bit memory that is read one column ahead of the
// input position, which is what lets the next cell follow at once. Rows above
// the grid are masked, so the memory needs no clearing after reset. Writing
// grid_width or grid_height restarts the frame.
`include "assert_macros.svh"

module wireworld_generation_step
    import ww_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    ww_cell_if.sink              in_ch,
    ww_result_if.source          out_ch
);

    logic [ADDR_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [17:0]        win_reg, win_next;
    logic [DIM_W-1:0]   h_reg;
    logic [COORD_W-1:0] wm1_reg, hm1_reg;

    logic               can_accept, accept, drain, active, restart;
    logic               first_col, last_col, emit, push;
    logic [1:0]         val, top, mid;
    ww_triple_t         trip, right;
    ww_pair_t           rd_pair, wr_pair;
    logic [DIM_W-1:0]   tr;
    logic [COORD_W-1:0] tc;
    logic [1:0]         rule_out;
    ww_result_t         result;
    logic [DIM_W-1:0]   w_clamped, h_clamped;
    logic               row_past_drain;

    assign in_ch.ready = can_accept;
    assign accept      = in_ch.valid && in_ch.ready;
    assign drain       = (row_reg >= h_reg);
    // flush words inside the frame are dropped
    assign active      = accept && (!in_ch.flush || drain);

    assign val  = drain ? CELL_EMPTY : in_ch.cell_state;
    assign top  = (row_reg >= DIM_W'(2)) ? rd_pair.upper  : CELL_EMPTY;
    assign mid  = (row_reg != '0)        ? rd_pair.middle : CELL_EMPTY;
    assign trip = {val, mid, top};

    assign wr_pair.upper  = mid;
    assign wr_pair.middle = val;

    assign first_col = (col_reg == '0);
    assign last_col  = (col_reg == wm1_reg);
    assign emit      = first_col ? (row_reg >= DIM_W'(2)) : (row_reg != '0);
    assign right     = first_col ? ww_triple_t'(0) : trip;
    assign tr        = first_col ? (row_reg - DIM_W'(2)) : (row_reg - DIM_W'(1));
    assign tc        = first_col ? wm1_reg : (col_reg - COORD_W'(1));
    assign push      = active && emit;

    ww_cell_rule u_rule (
        .left       (win_reg[11:6]),
        .cen        (win_reg[17:12]),
        .right      (right),
        .next_state (rule_out)
    );

    always_comb
    begin
        result.next_state        = rule_out;
        result.out_row           = tr[COORD_W-1:0];
        result.out_col           = tc;
        result.end_of_generation = (tr == {1'b0, hm1_reg}) && (tc == wm1_reg);
    end

    assign restart = cfg_we && ((cfg_index == REG_GRID_WIDTH) ||
                                (cfg_index == REG_GRID_HEIGHT));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        win_next = win_reg;
        if (active)
        begin
            win_next = first_col ? {trip, 12'd0} : {trip, win_reg[17:6]};
            if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + DIM_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
            if (push && result.end_of_generation)
            begin
                col_next = '0;
                row_next = '0;
                win_next = '0;
            end
        end
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
            win_next = '0;
        end
    end

    assign w_clamped = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
    assign h_clamped = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
            h_reg   <= DIM_W'(MAX_HEIGHT);
            wm1_reg <= COORD_W'(MAX_WIDTH - 1);
            hm1_reg <= COORD_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= win_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:
                        wm1_reg <= COORD_W'(w_clamped - DIM_W'(1));
                    REG_GRID_HEIGHT:
                    begin
                        h_reg   <= h_clamped;
                        hm1_reg <= COORD_W'(h_clamped - DIM_W'(1));
                    end
                    default: ;
                endcase
            end
        end
    end

    // read address follows the next position so the data is ready on time
    ww_line_mem u_lines (
        .clk     (clk),
        .wr_en   (active),
        .wr_addr (col_reg),
        .wr_data (wr_pair),
        .rd_addr (col_next),
        .rd_data (rd_pair)
    );

    ww_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (result),
        .can_accept (can_accept),
        .out_ch     (out_ch)
    );

    assign row_past_drain = ({1'b0, row_reg} > ({1'b0, h_reg} + (DIM_W + 1)'(1)));

    `ASSERT_CLK(a_stall_needs_pending, !in_ch.ready |-> out_ch.valid, "input stalled with empty queue")
    `ASSERT_CLK(a_restart_after_last, push && result.end_of_generation |=> (col_reg == '0) && (row_reg == '0), "position not cleared after last cell")
    `ASSERT_NEVER(a_row_bound, row_past_drain, "row counter ran past the drain rows")
    `ASSERT_NEVER(a_col_bound, col_reg > wm1_reg, "column counter ran past the row width")

endmodule
